[rtl/core/slwi_pkg.sv]
`default_nettype none

package slwi_pkg;

  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned OFS_W     = 8;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned START_W   = 9;
  localparam int unsigned MAX_LEN   = 256;
  localparam int unsigned TOTAL_MAX = 255;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ADDED    = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_ZERO_LEN = 3'd2;
  localparam status_t ST_WRITE    = 3'd3;
  localparam status_t ST_RANGE    = 3'd4;

  typedef struct packed {
    logic    load;
    logic    append;
    logic    step;
    logic    finish;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic len_zero;
    logic at_end;
    logic hit;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/slwi_ctrl.sv]
`default_nettype none

module slwi_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic start_i,
  input  wire                logic command_i,
  input  slwi_pkg::dp_stat_t stat_i,
  output slwi_pkg::dp_cmd_t  cmd_o,
  output                     logic busy_o
);

  import slwi_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPEND = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (command_i == CMD_WRITE) ? S_WALK : S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
        if (stat_i.full) begin
          cmd_o.status = ST_FULL;
        end else if (stat_i.len_zero) begin
          cmd_o.status = ST_ZERO_LEN;
        end else begin
          cmd_o.append = 1'b1;
          cmd_o.status = ST_ADDED;
        end
      end
      S_WALK: begin
        if (stat_i.at_end) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_RANGE;
          state_d      = S_IDLE;
        end else if (stat_i.hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_WRITE;
          state_d      = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_o)
    else $error("busy held after finish");

  a_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.finish && (cmd_o.step || cmd_o.load)))
    else $error("finish issued with step or load");

endmodule

`default_nettype wire

[rtl/core/slwi_dp.sv]
`default_nettype none

module slwi_dp #(
  parameter int unsigned MAX_SEGMENTS  = 16,
  parameter int unsigned ADDRESS_WIDTH = 16
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  slwi_pkg::dp_cmd_t  cmd_i,
  output slwi_pkg::dp_stat_t stat_o,
  input  wire                logic [ADDRESS_WIDTH-1:0]      base_address_i,
  input  wire                logic [slwi_pkg::LEN_W-1:0]    segment_length_i,
  input  wire                logic [slwi_pkg::OFS_W-1:0]    flat_index_i,
  input  wire                logic [slwi_pkg::DATA_W-1:0]   data_byte_i,
  output                     logic                          done_o,
  output slwi_pkg::status_t  status_o,
  output                     logic [ADDRESS_WIDTH-1:0]      write_address_o,
  output                     logic [slwi_pkg::DATA_W-1:0]   write_data_o,
  output                     logic [slwi_pkg::OFS_W-1:0]    total_indices_o
);

  import slwi_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned EntW = ADDRESS_WIDTH + OFS_W;

  logic [EntW-1:0] mem [MAX_SEGMENTS];
  logic [EntW-1:0] rdata_q;

  logic [ADDRESS_WIDTH-1:0] base_q;
  logic [LEN_W-1:0]         len_q;
  logic [OFS_W-1:0]         idx_q;
  logic [DATA_W-1:0]        data_q;

  logic [CntW-1:0]    count_q;
  logic [OFS_W-1:0]   total_q, total_d;
  logic [CntW-1:0]    ptr_q, ptr_d;
  logic [START_W-1:0] start_q, start_d;

  logic                     done_q;
  status_t                  status_q;
  logic [ADDRESS_WIDTH-1:0] addr_q;
  logic [DATA_W-1:0]        wdata_q;

  logic [LEN_W-1:0]         len_sat;
  logic [OFS_W-1:0]         last_ofs;
  logic [LEN_W:0]           total_sum;
  logic [ADDRESS_WIDTH-1:0] rd_base;
  logic [OFS_W-1:0]         rd_last;
  logic [START_W:0]         seg_end;
  logic [OFS_W-1:0]         offset;
  logic [ADDRESS_WIDTH-1:0] wr_addr;

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_address_i;
      len_q  <= segment_length_i;
      idx_q  <= flat_index_i;
      data_q <= data_byte_i;
    end
  end

  assign len_sat   = (len_q > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_q;
  assign last_ofs  = OFS_W'(len_sat - LEN_W'(1));
  assign total_sum = {2'b00, total_q} + {1'b0, len_sat};
  assign total_d   = (total_sum > (LEN_W + 1)'(TOTAL_MAX)) ? OFS_W'(TOTAL_MAX)
                                                            : total_sum[OFS_W-1:0];

  // segment table; read data belongs to the entry at ptr_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[count_q[IdxW-1:0]] <= {base_q, last_ofs};
    end
    rdata_q <= mem[ptr_d[IdxW-1:0]];
  end

  assign rd_base = rdata_q[EntW-1:OFS_W];
  assign rd_last = rdata_q[OFS_W-1:0];
  assign seg_end = {1'b0, start_q} + {2'b00, rd_last} + (START_W + 1)'(1);
  assign offset  = idx_q - start_q[OFS_W-1:0];
  assign wr_addr = rd_base + ADDRESS_WIDTH'(offset);

  always_comb begin
    ptr_d   = ptr_q;
    start_d = start_q;
    if (cmd_i.load) begin
      ptr_d   = '0;
      start_d = '0;
    end else if (cmd_i.step) begin
      ptr_d   = ptr_q + CntW'(1);
      start_d = (seg_end > (START_W + 1)'(MAX_LEN)) ? START_W'(MAX_LEN)
                                                     : seg_end[START_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      ptr_q   <= '0;
      start_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      start_q <= start_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.append) begin
        count_q <= count_q + CntW'(1);
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      if (cmd_i.status == ST_WRITE) begin
        addr_q  <= wr_addr;
        wdata_q <= data_q;
      end else begin
        addr_q  <= '0;
        wdata_q <= '0;
      end
    end
  end

  assign stat_o.full     = (count_q == CntW'(MAX_SEGMENTS));
  assign stat_o.len_zero = (len_q == '0);
  assign stat_o.at_end   = (ptr_q == count_q);
  assign stat_o.hit      = ({2'b00, idx_q} < seg_end);

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign write_address_o = addr_q;
  assign write_data_o    = wdata_q;
  assign total_indices_o = total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_idle_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != ST_WRITE) |-> (addr_q == '0 && wdata_q == '0))
    else $error("write payload set without a write");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> (count_q - $past(count_q)) == CntW'(1))
    else $error("append did not advance the segment count");

endmodule

`default_nettype wire

[rtl/core/segment_list_index_writer.sv]
`default_nettype none
// Append: done_o strobes (registered) after the APPEND state; busy_o is low again in that cycle.
// Write transaction: done_o strobes once the table walk has passed over the segments before the
// index (one entry per cycle from a registered-read table), or over every segment when the index
// lies beyond them all.
// Results are not back-pressured; reset empties the segment table and clears the index total.

module segment_list_index_writer #(
  parameter int unsigned MAX_SEGMENTS  = 16,
  parameter int unsigned ADDRESS_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output      logic                           busy_o,
  input  wire logic                           command_i,
  input  wire logic [ADDRESS_WIDTH-1:0]       base_address_i,
  input  wire logic [slwi_pkg::LEN_W-1:0]     segment_length_i,
  input  wire logic [slwi_pkg::OFS_W-1:0]     flat_index_i,
  input  wire logic [slwi_pkg::DATA_W-1:0]    data_byte_i,
  output      logic                           done_o,
  output      logic [slwi_pkg::STATUS_W-1:0]  status_o,
  output      logic [ADDRESS_WIDTH-1:0]       write_address_o,
  output      logic [slwi_pkg::DATA_W-1:0]    write_data_o,
  output      logic [slwi_pkg::OFS_W-1:0]     total_indices_o
);

  import slwi_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  status_t  dp_status;

  slwi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy_o    (busy_o)
  );

  slwi_dp #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .base_address_i   (base_address_i),
    .segment_length_i (segment_length_i),
    .flat_index_i     (flat_index_i),
    .data_byte_i      (data_byte_i),
    .done_o           (done_o),
    .status_o         (dp_status),
    .write_address_o  (write_address_o),
    .write_data_o     (write_data_o),
    .total_indices_o  (total_indices_o)
  );

  assign status_o = dp_status;

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import slwi_pkg::*;

  localparam int unsigned MAX_SEGMENTS  = 16;
  localparam int unsigned ADDRESS_WIDTH = 16;
  localparam int unsigned STALL_LIMIT   = 1000;

  typedef struct packed {
    logic                     cmd;
    logic [ADDRESS_WIDTH-1:0] base;
    logic [LEN_W-1:0]         len;
    logic [OFS_W-1:0]         idx;
    logic [DATA_W-1:0]        data;
  } seg_cmd_t;

  typedef struct packed {
    status_t                  status;
    logic [ADDRESS_WIDTH-1:0] addr;
    logic [DATA_W-1:0]        data;
    logic [OFS_W-1:0]         total;
  } seg_result_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     start_i          = 1'b0;
  logic                     command_i        = CMD_APPEND;
  logic [ADDRESS_WIDTH-1:0] base_address_i   = '0;
  logic [LEN_W-1:0]         segment_length_i = '0;
  logic [OFS_W-1:0]         flat_index_i     = '0;
  logic [DATA_W-1:0]        data_byte_i      = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [STATUS_W-1:0]      status_o;
  logic [ADDRESS_WIDTH-1:0] write_address_o;
  logic [DATA_W-1:0]        write_data_o;
  logic [OFS_W-1:0]         total_indices_o;

  segment_list_index_writer #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .base_address_i  (base_address_i),
    .segment_length_i(segment_length_i),
    .flat_index_i    (flat_index_i),
    .data_byte_i     (data_byte_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .total_indices_o (total_indices_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Own copy of the segment table
  logic [ADDRESS_WIDTH-1:0] seg_base [MAX_SEGMENTS];
  logic [OFS_W-1:0]         seg_last [MAX_SEGMENTS];
  int unsigned              seg_count   = 0;
  int unsigned              index_total = 0;

  seg_cmd_t    pending_cmds[$];
  seg_result_t expected_results[$];
  seg_cmd_t    cur_cmd;
  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned gap_left       = 0;
  int unsigned calm_left      = 0;
  int unsigned roll;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;

  function automatic seg_result_t translate_cmd(seg_cmd_t c);
    seg_result_t r;
    int unsigned walk_start;
    int unsigned seg_len;
    logic        hit;
    r = '0;
    if (c.cmd == CMD_APPEND) begin
      if (seg_count >= MAX_SEGMENTS) begin
        r.status = ST_FULL;
      end else if (c.len == 0) begin
        r.status = ST_ZERO_LEN;
      end else begin
        seg_len = (c.len > MAX_LEN) ? MAX_LEN : c.len;
        seg_base[seg_count] = c.base;
        seg_last[seg_count] = OFS_W'(seg_len - 1);
        seg_count++;
        index_total = index_total + seg_len;
        if (index_total > TOTAL_MAX) index_total = TOTAL_MAX;
        r.status = ST_ADDED;
      end
    end else begin
      r.status   = ST_RANGE;
      hit        = 1'b0;
      walk_start = 0;
      for (int i = 0; i < seg_count; i++) begin
        seg_len = seg_last[i] + 1;
        if (!hit && c.idx < walk_start + seg_len) begin
          hit      = 1'b1;
          r.status = ST_WRITE;
          r.addr   = ADDRESS_WIDTH'(seg_base[i] + (c.idx - walk_start));
          r.data   = c.data;
        end
        walk_start += seg_len;
      end
    end
    r.total = index_total[OFS_W-1:0];
    return r;
  endfunction

  function automatic seg_cmd_t rand_write(int unsigned idx_hi);
    seg_cmd_t c;
    c.cmd  = CMD_WRITE;
    c.base = ADDRESS_WIDTH'($urandom);
    c.len  = LEN_W'($urandom_range(511, 0));
    c.idx  = OFS_W'($urandom_range(idx_hi, 0));
    c.data = DATA_W'($urandom);
    return c;
  endfunction

  function automatic seg_cmd_t rand_append(int unsigned len_lo, int unsigned len_hi);
    seg_cmd_t c;
    c.cmd  = CMD_APPEND;
    c.base = ADDRESS_WIDTH'($urandom);
    c.len  = LEN_W'($urandom_range(len_hi, len_lo));
    c.idx  = OFS_W'($urandom);
    c.data = DATA_W'($urandom);
    return c;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.push_back(translate_cmd(cur_cmd));
        accepted_count++;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(99, 0);
          if (roll < 3) calm_left = $urandom_range(60, 20);
          if (roll < 55) gap_left = 0;
          else if (roll < 85) gap_left = $urandom_range(3, 1);
          else if (roll < 97) gap_left = $urandom_range(10, 4);
          else gap_left = $urandom_range(60, 20);
        end
      end
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          command_i        <= cur_cmd.cmd;
          base_address_i   <= cur_cmd.base;
          segment_length_i <= cur_cmd.len;
          flat_index_i     <= cur_cmd.idx;
          data_byte_i      <= cur_cmd.data;
          start_i          <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    seg_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", status_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (write_address_o !== want.addr)
          report_mismatch("write_address", write_address_o, want.addr);
        if (write_data_o !== want.data) report_mismatch("write_data", write_data_o, want.data);
        if (total_indices_o !== want.total)
          report_mismatch("total_indices", total_indices_o, want.total);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gen_count;
    int unsigned gen_total;
    int unsigned len;
    gen_count = 2;
    gen_total = 5;

    // empty table, zero length, address wrap, index extremes
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'h0000, 9'd0,   8'd0,   8'hA5});
    pending_cmds.push_back(seg_cmd_t'{CMD_APPEND, 16'hFFFF, 9'd0,   8'd255, 8'hFF});
    pending_cmds.push_back(seg_cmd_t'{CMD_APPEND, 16'hFFFE, 9'd4,   8'd0,   8'h00});
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'h0000, 9'd0,   8'd3,   8'hFF});
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'hFFFF, 9'd511, 8'd4,   8'h5A});
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'h1234, 9'd1,   8'd0,   8'h00});
    pending_cmds.push_back(seg_cmd_t'{CMD_APPEND, 16'h0000, 9'd1,   8'd17,  8'h3C});
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'h0000, 9'd0,   8'd4,   8'h00});
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'h0000, 9'd0,   8'd255, 8'hFF});

    // fill to one short of full with short segments
    while (gen_count < MAX_SEGMENTS - 1) begin
      roll = $urandom_range(99, 0);
      if (roll < 2) begin
        pending_cmds.push_back(rand_append(0, 0));
      end else if (roll < 8) begin
        len = $urandom_range(16, 1);
        pending_cmds.push_back(rand_append(len, len));
        gen_count++;
        gen_total += len;
      end else begin
        pending_cmds.push_back(rand_write(gen_total + 8));
      end
    end

    // deep walks, some beyond every segment
    repeat (500) begin
      if ($urandom_range(99, 0) < 5) pending_cmds.push_back(rand_append(0, 0));
      else pending_cmds.push_back(rand_write(gen_total + 8 > 255 ? 255 : gen_total + 8));
    end

    // last segment overlong: saturates the total and fills the table
    pending_cmds.push_back(seg_cmd_t'{CMD_APPEND, 16'hFFFF, 9'h1FF, 8'd0, 8'h00});
    pending_cmds.push_back(seg_cmd_t'{CMD_WRITE,  16'h0000, 9'd0,   8'd255, 8'hC3});
    pending_cmds.push_back(seg_cmd_t'{CMD_APPEND, 16'h0000, 9'd0,   8'd0,   8'h00});

    repeat (1000) begin
      if ($urandom_range(99, 0) < 15) pending_cmds.push_back(rand_append(0, 511));
      else pending_cmds.push_back(rand_write(255));
    end
    issued_count = pending_cmds.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (MAX_SEGMENTS + 4) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0 &&
        accepted_count == issued_count) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
